// ===== rtl/bfd_pkg.sv =====
// shared types and constants for the box filter downscale unit
package bfd_pkg;

    localparam int PIX_W      = 8;
    localparam int LANES_MAX  = 4;
    localparam int SUM_W      = 20;
    localparam int CNT_W      = 12;
    localparam int FAC_W      = 7;
    localparam int AREA_W     = 14;
    localparam int DIM_W      = 13;
    localparam int OWR_W      = 11;
    localparam int CH_W       = 3;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 13;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int IN_W       = LANES_MAX * PIX_W;
    localparam int OUT_W      = 56;

    typedef enum logic [IDX_W-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_FACTOR_X   = 3'd2,
        REG_FACTOR_Y   = 3'd3,
        REG_OUT_WIDTH  = 3'd4,
        REG_OUT_HEIGHT = 3'd5,
        REG_CHANNELS   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]  sw;
        logic [DIM_W-1:0]  sh;
        logic [FAC_W-1:0]  fx;
        logic [FAC_W-1:0]  fy;
        logic [DIM_W-1:0]  ow;
        logic [DIM_W-1:0]  oh;
        logic [CH_W-1:0]   nch;
        logic [AREA_W-1:0] area;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic accum;
        logic div_start;
        logic div_step;
        logic sync_start;
        logic sync_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic last;
        logic div_done;
        logic sync_done;
    } t_sts;

endpackage

// ===== rtl/bfd_ctrl.sv =====
// controller state machine for the box filter downscale unit
module bfd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  bfd_pkg::t_sts i_sts,
    output bfd_pkg::t_cmd o_cmd
);
    import bfd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SYNC = 5'b00010,
        ST_ADD  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_pend, n_pend;
    logic   r_ovld, n_ovld;

    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_ovld      = r_ovld;
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        o_cfg_ready = 1'b0;
        if (r_ovld && i_m_tready) begin
            n_ovld = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                o_cfg_ready = 1'b1;
                o_s_tready  = !r_pend && !i_cfg_valid;
                if (i_cfg_valid) begin
                    n_pend = 1'b1;
                end else if (r_pend) begin
                    o_cmd.sync_start = 1'b1;
                    n_pend           = 1'b0;
                    n_state          = ST_SYNC;
                end else if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.in_range) begin
                        n_state = ST_ADD;
                    end
                end
            end
            ST_SYNC: begin
                o_cmd.sync_step = 1'b1;
                if (i_sts.sync_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ADD: begin
                o_cmd.accum = 1'b1;
                if (i_sts.last) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_ovld || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovld         = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_ovld  <= n_ovld;
        end
    end

    assign o_m_tvalid = r_ovld;

endmodule

// ===== rtl/bfd_datapath.sv =====
// position counters, column sum memory, mean dividers and result register
module bfd_datapath #(
    parameter int MAX_OUT_WIDTH = 1024,
    parameter int CHANNEL_COUNT = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bfd_pkg::t_cfg         i_cfg,
    input  bfd_pkg::t_cmd         i_cmd,
    input  logic [bfd_pkg::IN_W-1:0]  i_pix,
    output logic [bfd_pkg::OUT_W-1:0] o_data,
    output logic                  o_last,
    output bfd_pkg::t_sts         o_sts
);
    import bfd_pkg::*;

    localparam int AW       = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int MEM_W    = CHANNEL_COUNT * SUM_W;
    localparam int DCNT_W   = $clog2(SUM_W);
    localparam int SCNT_W   = $clog2(CNT_W);
    localparam int DIV_LAST = SUM_W - 1;
    localparam int SYN_LAST = CNT_W - 1;

    // position state
    logic [CNT_W-1:0] r_col, r_row, r_ox, r_oy;
    logic [FAC_W-1:0] r_dx, r_dy;
    logic [CNT_W-1:0] n_col, n_row, n_ox, n_oy;
    logic [FAC_W-1:0] n_dx, n_dy;

    // item in flight
    logic [PIX_W-1:0] r_px [CHANNEL_COUNT];
    logic             r_first, r_last, r_flast;
    logic [AW-1:0]    r_addr;
    logic [COL_W-1:0] r_icol;
    logic [ROW_W-1:0] r_irow;
    logic [MEM_W-1:0] r_rd;
    logic [MEM_W-1:0] r_mem [MAX_OUT_WIDTH];
    logic [MEM_W-1:0] n_wr;

    // mean dividers
    logic [SUM_W-1:0]  r_dnum [CHANNEL_COUNT];
    logic [AREA_W-1:0] r_drem [CHANNEL_COUNT];
    logic [PIX_W-1:0]  r_dq   [CHANNEL_COUNT];
    logic [AREA_W-1:0] n_drem [CHANNEL_COUNT];
    logic              n_dbit [CHANNEL_COUNT];
    logic [DCNT_W-1:0] r_dcnt;

    // position resync dividers
    logic [CNT_W-1:0]  r_sn_c, r_sn_r, r_sq_c, r_sq_r;
    logic [FAC_W-1:0]  r_sr_c, r_sr_r;
    logic [FAC_W:0]    s_tc, s_tr;
    logic              s_gc, s_gr;
    logic [FAC_W-1:0]  n_sr_c, n_sr_r;
    logic [CNT_W-1:0]  n_sq_c, n_sq_r;
    logic [SCNT_W-1:0] r_scnt;

    // result register
    logic [PIX_W-1:0] r_avg [LANES_MAX];
    logic [COL_W-1:0] r_ocol;
    logic [ROW_W-1:0] r_orow;
    logic             r_oflast;

    logic [DIM_W-1:0] col_inc, row_inc;
    logic [FAC_W:0]   dx_inc, dy_inc;
    logic             col_end, row_end, dx_wrap, dy_wrap;
    logic             cur_first, cur_last, cur_flast;
    logic [LANES_MAX-1:0] ch_en;

    always_comb begin
        col_inc   = {1'b0, r_col} + DIM_W'(1);
        row_inc   = {1'b0, r_row} + DIM_W'(1);
        dx_inc    = {1'b0, r_dx} + (FAC_W+1)'(1);
        dy_inc    = {1'b0, r_dy} + (FAC_W+1)'(1);
        col_end   = col_inc >= i_cfg.sw;
        row_end   = row_inc >= i_cfg.sh;
        dx_wrap   = dx_inc == {1'b0, i_cfg.fx};
        dy_wrap   = dy_inc == {1'b0, i_cfg.fy};
        cur_first = (r_dx == '0) && (r_dy == '0);
        cur_last  = dx_wrap && dy_wrap;
        cur_flast = ({1'b0, r_ox} == i_cfg.ow - DIM_W'(1)) &&
                    ({1'b0, r_oy} == i_cfg.oh - DIM_W'(1));
        for (int l = 0; l < LANES_MAX; l++) begin
            ch_en[l] = CH_W'(l) < i_cfg.nch;
        end

        n_col = r_col;
        n_row = r_row;
        n_ox  = r_ox;
        n_oy  = r_oy;
        n_dx  = r_dx;
        n_dy  = r_dy;
        if (col_end) begin
            n_col = '0;
            n_dx  = '0;
            n_ox  = '0;
            if (row_end) begin
                n_row = '0;
                n_dy  = '0;
                n_oy  = '0;
            end else begin
                n_row = row_inc[CNT_W-1:0];
                if (dy_wrap) begin
                    n_dy = '0;
                    n_oy = r_oy + CNT_W'(1);
                end else begin
                    n_dy = dy_inc[FAC_W-1:0];
                end
            end
        end else begin
            n_col = col_inc[CNT_W-1:0];
            if (dx_wrap) begin
                n_dx = '0;
                n_ox = r_ox + CNT_W'(1);
            end else begin
                n_dx = dx_inc[FAC_W-1:0];
            end
        end

        s_tc   = {r_sr_c, r_sn_c[CNT_W-1]};
        s_tr   = {r_sr_r, r_sn_r[CNT_W-1]};
        s_gc   = s_tc >= {1'b0, i_cfg.fx};
        s_gr   = s_tr >= {1'b0, i_cfg.fy};
        n_sr_c = s_gc ? FAC_W'(s_tc - {1'b0, i_cfg.fx}) : FAC_W'(s_tc);
        n_sr_r = s_gr ? FAC_W'(s_tr - {1'b0, i_cfg.fy}) : FAC_W'(s_tr);
        n_sq_c = {r_sq_c[CNT_W-2:0], s_gc};
        n_sq_r = {r_sq_r[CNT_W-2:0], s_gr};
    end

    always_comb begin
        logic [AREA_W:0] trial;
        for (int l = 0; l < CHANNEL_COUNT; l++) begin
            n_wr[l*SUM_W +: SUM_W] = (r_first ? SUM_W'(0) : r_rd[l*SUM_W +: SUM_W]) +
                                     SUM_W'(r_px[l]);
            trial     = {r_drem[l], r_dnum[l][SUM_W-1]};
            n_dbit[l] = trial >= {1'b0, i_cfg.area};
            n_drem[l] = n_dbit[l] ? AREA_W'(trial - {1'b0, i_cfg.area}) : AREA_W'(trial);
        end
    end

    // column sum memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd <= r_mem[r_ox[AW-1:0]];
        end
        if (i_cmd.accum) begin
            r_mem[r_addr] <= n_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_ox   <= '0;
            r_oy   <= '0;
            r_dx   <= '0;
            r_dy   <= '0;
            r_scnt <= '0;
            r_dcnt <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_col <= n_col;
                r_row <= n_row;
                r_ox  <= n_ox;
                r_oy  <= n_oy;
                r_dx  <= n_dx;
                r_dy  <= n_dy;
            end
            if (i_cmd.sync_start) begin
                r_scnt <= '0;
            end else if (i_cmd.sync_step) begin
                r_scnt <= r_scnt + SCNT_W'(1);
                if (o_sts.sync_done) begin
                    r_dx <= n_sr_c;
                    r_ox <= n_sq_c;
                    r_dy <= n_sr_r;
                    r_oy <= n_sq_r;
                end
            end
            if (i_cmd.div_start) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_first <= cur_first;
            r_last  <= cur_last;
            r_flast <= cur_flast;
            r_addr  <= r_ox[AW-1:0];
            r_icol  <= r_ox[COL_W-1:0];
            r_irow  <= r_oy[ROW_W-1:0];
            for (int l = 0; l < CHANNEL_COUNT; l++) begin
                r_px[l] <= ch_en[l] ? i_pix[l*PIX_W +: PIX_W] : '0;
            end
        end
        if (i_cmd.sync_start) begin
            r_sn_c <= r_col;
            r_sn_r <= r_row;
            r_sr_c <= '0;
            r_sr_r <= '0;
            r_sq_c <= '0;
            r_sq_r <= '0;
        end else if (i_cmd.sync_step) begin
            r_sn_c <= {r_sn_c[CNT_W-2:0], 1'b0};
            r_sn_r <= {r_sn_r[CNT_W-2:0], 1'b0};
            r_sr_c <= n_sr_c;
            r_sr_r <= n_sr_r;
            r_sq_c <= n_sq_c;
            r_sq_r <= n_sq_r;
        end
        for (int l = 0; l < CHANNEL_COUNT; l++) begin
            if (i_cmd.div_start) begin
                r_dnum[l] <= n_wr[l*SUM_W +: SUM_W];
                r_drem[l] <= '0;
                r_dq[l]   <= '0;
            end else if (i_cmd.div_step) begin
                r_dnum[l] <= {r_dnum[l][SUM_W-2:0], 1'b0};
                r_drem[l] <= n_drem[l];
                r_dq[l]   <= {r_dq[l][PIX_W-2:0], n_dbit[l]};
            end
        end
        if (i_cmd.out_load) begin
            r_ocol   <= r_icol;
            r_orow   <= r_irow;
            r_oflast <= r_flast;
        end
    end

    genvar g;
    generate
        for (g = 0; g < LANES_MAX; g++) begin : g_lane
            if (g < CHANNEL_COUNT) begin : g_used
                always_ff @(posedge i_clk) begin
                    if (i_cmd.out_load) begin
                        r_avg[g] <= ch_en[g] ? r_dq[g] : '0;
                    end
                end
            end else begin : g_unused
                assign r_avg[g] = '0;
            end
        end
    endgenerate

    always_comb begin
        o_sts.in_range  = ({1'b0, r_ox} < i_cfg.ow) && ({1'b0, r_oy} < i_cfg.oh);
        o_sts.last      = r_last;
        o_sts.div_done  = r_dcnt == DCNT_W'(DIV_LAST);
        o_sts.sync_done = r_scnt == SCNT_W'(SYN_LAST);
    end

    assign o_data = {2'b00, r_orow, r_ocol, r_avg[3], r_avg[2], r_avg[1], r_avg[0]};
    assign o_last = r_oflast;

endmodule

// ===== rtl/box_filter_downscale_unit.sv =====
// top level of the box filter downscale unit: registers, controller and datapath
// Pixels enter in raster order and each factor_x by factor_y block yields one
// output pixel, the truncated per-channel mean, with its column and row. A pixel
// inside the output area is taken with a memory read and then accumulated and
// written back into the per-output-column sum memory; a pixel outside it advances
// the position counters and is not accumulated. The pixel that closes a block then
// runs the bit-serial mean divider and the result load, and its result waits while
// an earlier result is still held at the output. After any register write the
// position counters are realigned to the new factors by a bit-serial divider, a
// start and then twelve steps, before the next pixel is taken. Registers are written
// only while no pixel is in flight.
module box_filter_downscale_unit #(
    parameter int MAX_OUT_WIDTH = 1024,
    parameter int MAX_FACTOR    = 64,
    parameter int CHANNEL_COUNT = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // pixel_c0, pixel_c1, pixel_c2, pixel_c3
    input  logic [bfd_pkg::IN_W-1:0]         i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // avg_c0, avg_c1, avg_c2, avg_c3, out_col, out_row, zero pad
    output logic [bfd_pkg::OUT_W-1:0]        o_m_tdata,
    // frame_last
    output logic                             o_m_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bfd_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [bfd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bfd_pkg::*;

    logic [DIM_W-1:0] r_src_width, r_src_height, r_out_height;
    logic [FAC_W-1:0] r_factor_x, r_factor_y;
    logic [OWR_W-1:0] r_out_width;
    logic [CH_W-1:0]  r_channels;
    t_cfg             cfg;
    t_cmd             cmd;
    t_sts             sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= DIM_W'(1);
            r_src_height <= DIM_W'(1);
            r_factor_x   <= FAC_W'(1);
            r_factor_y   <= FAC_W'(1);
            r_out_width  <= OWR_W'(1);
            r_out_height <= DIM_W'(1);
            r_channels   <= CH_W'(4);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                REG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                REG_FACTOR_X:   r_factor_x   <= i_cfg_data[FAC_W-1:0];
                REG_FACTOR_Y:   r_factor_y   <= i_cfg_data[FAC_W-1:0];
                REG_OUT_WIDTH:  r_out_width  <= i_cfg_data[OWR_W-1:0];
                REG_OUT_HEIGHT: r_out_height <= i_cfg_data;
                REG_CHANNELS:   r_channels   <= i_cfg_data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp to legal ranges, zero counts as one
    always_comb begin
        cfg.sw  = (r_src_width == '0) ? DIM_W'(1) :
                  (r_src_width > DIM_W'(4096)) ? DIM_W'(4096) : r_src_width;
        cfg.sh  = (r_src_height == '0) ? DIM_W'(1) :
                  (r_src_height > DIM_W'(4096)) ? DIM_W'(4096) : r_src_height;
        cfg.fx  = (r_factor_x == '0) ? FAC_W'(1) :
                  (int'(r_factor_x) > MAX_FACTOR) ? FAC_W'(MAX_FACTOR) : r_factor_x;
        cfg.fy  = (r_factor_y == '0) ? FAC_W'(1) :
                  (int'(r_factor_y) > MAX_FACTOR) ? FAC_W'(MAX_FACTOR) : r_factor_y;
        cfg.ow  = (r_out_width == '0) ? DIM_W'(1) :
                  (int'(r_out_width) > MAX_OUT_WIDTH) ? DIM_W'(MAX_OUT_WIDTH) :
                  DIM_W'(r_out_width);
        cfg.oh  = (r_out_height == '0) ? DIM_W'(1) :
                  (r_out_height > DIM_W'(4096)) ? DIM_W'(4096) : r_out_height;
        cfg.nch = (r_channels == '0) ? CH_W'(1) :
                  (int'(r_channels) > CHANNEL_COUNT) ? CH_W'(CHANNEL_COUNT) : r_channels;
        cfg.area = AREA_W'(cfg.fx) * AREA_W'(cfg.fy);
    end

    bfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bfd_datapath #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (cmd),
        .i_pix   (i_s_tdata),
        .o_data  (o_m_tdata),
        .o_last  (o_m_tlast),
        .o_sts   (sts)
    );

endmodule

// ===== verif/tb_box_filter_downscale_unit.sv =====
// self-checking testbench for the box filter downscale unit with a built-in block mean predictor
module tb_box_filter_downscale_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import bfd_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 3000;

    typedef struct {
        bit              is_cfg;
        t_reg_idx        idx;
        logic [12:0]     val;
        logic [31:0]     pix;
        int              gap;
    } t_job;

    typedef struct packed {
        logic [7:0]  a0;
        logic [7:0]  a1;
        logic [7:0]  a2;
        logic [7:0]  a3;
        logic [9:0]  col;
        logic [11:0] row;
        logic        last;
    } t_mean_px;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_W-1:0]       i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_W-1:0]      o_m_tdata;
    logic                  o_m_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    box_filter_downscale_unit i_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_job        pending_jobs[$];
    t_mean_px    expected_means[$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    bit          idle_on = 1'b1;
    bit          stall_on = 1'b1;
    int          results_seen = 0;

    // predictor state
    logic [12:0] p_sw = 13'd1, p_sh = 13'd1, p_ow = 13'd1, p_oh = 13'd1;
    logic [6:0]  p_fx = 7'd1, p_fy = 7'd1;
    logic [2:0]  p_nch = 3'd4;
    logic [19:0] block_sum[4][1024];
    int          src_col = 0, src_row = 0;

    function automatic int clampu(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic bit accumulate_pixel(input logic [31:0] pix, output t_mean_px r);
        int sw, sh, fx, fy, ow, oh, nch, ox, oy, dx, dy, area;
        logic [7:0] m[4];
        logic [19:0] px;
        bit first, closes, got;
        sw = clampu(p_sw, 1, 4096);
        sh = clampu(p_sh, 1, 4096);
        fx = clampu(p_fx, 1, 64);
        fy = clampu(p_fy, 1, 64);
        ow = clampu(p_ow, 1, 1024);
        oh = clampu(p_oh, 1, 4096);
        nch = clampu(p_nch, 1, 4);
        ox = src_col / fx;
        oy = src_row / fy;
        dx = src_col % fx;
        dy = src_row % fy;
        area = fx * fy;
        got = 1'b0;
        r = '0;
        if (ox < ow && oy < oh) begin
            first = (dx == 0 && dy == 0);
            closes = (dx == fx - 1 && dy == fy - 1);
            for (int ch = 0; ch < 4; ch++) begin
                px = (ch < nch) ? 20'(pix[8*ch +: 8]) : 20'd0;
                block_sum[ch][ox] = (first ? 20'd0 : block_sum[ch][ox]) + px;
                m[ch] = (ch < nch) ? 8'(block_sum[ch][ox] / area) : 8'd0;
            end
            if (closes) begin
                r.a0 = m[0];
                r.a1 = m[1];
                r.a2 = m[2];
                r.a3 = m[3];
                r.col = 10'(ox);
                r.row = 12'(oy);
                r.last = (ox == ow - 1 && oy == oh - 1);
                got = 1'b1;
            end
        end
        if (src_col + 1 >= sw) begin
            src_col = 0;
            src_row = (src_row + 1 >= sh) ? 0 : ((src_row + 1) & 12'hFFF);
        end else begin
            src_col = (src_col + 1) & 12'hFFF;
        end
        return got;
    endfunction

    // stimulus builders
    task automatic queue_cfg(t_reg_idx idx, int val);
        t_job j;
        j.is_cfg = 1'b1;
        j.idx = idx;
        j.val = 13'(val);
        j.pix = '0;
        j.gap = 0;
        pending_jobs.push_back(j);
    endtask

    task automatic queue_pixel(logic [31:0] pix);
        t_job j;
        j.is_cfg = 1'b0;
        j.idx = REG_SRC_WIDTH;
        j.val = '0;
        j.pix = pix;
        j.gap = idle_on ? $urandom_range(0, 7) : 0;
        pending_jobs.push_back(j);
    endtask

    task automatic queue_setup(int sw, int sh, int fx, int fy, int ow, int oh, int nch);
        queue_cfg(REG_SRC_WIDTH, sw);
        queue_cfg(REG_SRC_HEIGHT, sh);
        queue_cfg(REG_FACTOR_X, fx);
        queue_cfg(REG_FACTOR_Y, fy);
        queue_cfg(REG_OUT_WIDTH, ow);
        queue_cfg(REG_OUT_HEIGHT, oh);
        queue_cfg(REG_CHANNELS, nch);
    endtask

    // whole frames only, so the position counters are back at zero before the next setup
    task automatic queue_frames(int npix, int frames, int fill);
        idle_on = ($urandom_range(0, 3) != 0);
        for (int f = 0; f < frames; f++) begin
            for (int p = 0; p < npix; p++) begin
                case (fill)
                    1: queue_pixel(32'hFFFF_FFFF);
                    2: queue_pixel(32'h0);
                    default: queue_pixel($urandom);
                endcase
            end
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        bit  s_busy, c_busy;
        t_job j;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_cfg_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            s_busy = i_s_tvalid && !o_s_tready;
            c_busy = i_cfg_valid && !o_cfg_ready;
            if (!s_busy && !c_busy) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_s_tvalid <= 1'b0;
                    i_cfg_valid <= 1'b0;
                end else if (pending_jobs.size() > 0 && !pending_jobs[0].is_cfg) begin
                    j = pending_jobs.pop_front();
                    i_s_tdata <= j.pix;
                    i_s_tvalid <= 1'b1;
                    i_cfg_valid <= 1'b0;
                    gap_left <= j.gap;
                end else if (pending_jobs.size() > 0 && expected_means.size() == 0 &&
                             !i_s_tvalid && quiet_cycles >= DRAIN_CYCLES) begin
                    j = pending_jobs.pop_front();
                    i_cfg_index <= j.idx;
                    i_cfg_data <= j.val;
                    i_cfg_valid <= 1'b1;
                    i_s_tvalid <= 1'b0;
                    gap_left <= $urandom_range(0, 2);
                end else begin
                    i_s_tvalid <= 1'b0;
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // input side: predict on every accepted beat, track register writes
    always @(posedge i_clk) begin
        t_mean_px r;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                if (accumulate_pixel(i_s_tdata, r)) expected_means.push_back(r);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_SRC_WIDTH:  p_sw <= i_cfg_data;
                    REG_SRC_HEIGHT: p_sh <= i_cfg_data;
                    REG_FACTOR_X:   p_fx <= i_cfg_data[6:0];
                    REG_FACTOR_Y:   p_fy <= i_cfg_data[6:0];
                    REG_OUT_WIDTH:  p_ow <= {2'b0, i_cfg_data[10:0]};
                    REG_OUT_HEIGHT: p_oh <= i_cfg_data;
                    REG_CHANNELS:   p_nch <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if ((i_s_tvalid && o_s_tready) || expected_means.size() > 0 || o_m_tvalid)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // output side: random stalls and checking
    always @(posedge i_clk) begin
        t_mean_px e;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen <= results_seen + 1;
                if (results_seen % 64 == 63) stall_on <= ~stall_on;
                if (expected_means.size() == 0) begin
                    $error("unexpected beat: tdata %h tlast %b", o_m_tdata, o_m_tlast);
                    mismatches <= mismatches + 1;
                end else begin
                    e = expected_means.pop_front();
                    if (o_m_tdata[7:0] !== e.a0 || o_m_tdata[15:8] !== e.a1 ||
                        o_m_tdata[23:16] !== e.a2 || o_m_tdata[31:24] !== e.a3 ||
                        o_m_tdata[41:32] !== e.col || o_m_tdata[53:42] !== e.row ||
                        o_m_tlast !== e.last)
                        mismatches <= mismatches + 1;
                    if (o_m_tdata[7:0] !== e.a0)
                        $error("avg_c0 expected %0d actual %0d", e.a0, o_m_tdata[7:0]);
                    if (o_m_tdata[15:8] !== e.a1)
                        $error("avg_c1 expected %0d actual %0d", e.a1, o_m_tdata[15:8]);
                    if (o_m_tdata[23:16] !== e.a2)
                        $error("avg_c2 expected %0d actual %0d", e.a2, o_m_tdata[23:16]);
                    if (o_m_tdata[31:24] !== e.a3)
                        $error("avg_c3 expected %0d actual %0d", e.a3, o_m_tdata[31:24]);
                    if (o_m_tdata[41:32] !== e.col)
                        $error("out_col expected %0d actual %0d", e.col, o_m_tdata[41:32]);
                    if (o_m_tdata[53:42] !== e.row)
                        $error("out_row expected %0d actual %0d", e.row, o_m_tdata[53:42]);
                    if (o_m_tlast !== e.last)
                        $error("frame_last expected %0d actual %0d", e.last, o_m_tlast);
                end
                stall_left <= stall_on ? $urandom_range(0, 7) : 0;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int pixels_left, sw, sh, fx, fy, ow, oh, nch, frames;
        // reset setup passes every pixel through as its own block
        queue_pixel(32'h0000_0000);
        queue_pixel(32'hFFFF_FFFF);
        queue_pixel(32'hAA55_AA55);
        queue_pixel(32'h55AA_55AA);
        queue_pixel(32'h0102_0408);
        queue_pixel(32'h8040_2010);
        queue_setup(4, 4, 2, 2, 2, 2, 4);
        queue_frames(16, 1, 0);
        queue_frames(16, 1, 1);
        // trailing columns and rows ignored
        queue_setup(7, 5, 3, 2, 2, 2, 3);
        queue_frames(35, 1, 0);
        queue_setup(7, 3, 2, 3, 3, 1, 2);
        queue_frames(21, 1, 0);
        // factors too large for the source: no blocks close
        queue_setup(5, 5, 8, 8, 1, 1, 1);
        queue_frames(25, 1, 0);
        // an 8 by 8 block at full scale
        queue_setup(8, 8, 8, 8, 1, 1, 4);
        queue_frames(64, 1, 1);
        // out-of-range register values clamp
        queue_setup(0, 64, 0, 127, 2047, 8191, 0);
        queue_frames(64, 1, 0);
        queue_setup(128, 0, 127, 0, 2047, 0, 7);
        queue_frames(128, 1, 0);
        pixels_left = 700;
        while (pixels_left > 0) begin
            fx = $urandom_range(1, 4);
            fy = $urandom_range(1, 4);
            ow = $urandom_range(1, 4);
            oh = $urandom_range(1, 3);
            sw = ow * fx + $urandom_range(0, 2);
            sh = oh * fy + $urandom_range(0, 2);
            if ($urandom_range(0, 7) == 0) begin
                fx = $urandom_range(1, 16);
                sw = clampu(ow * fx - $urandom_range(0, fx), 1, 4096);
            end
            nch = $urandom_range(0, 7);
            frames = $urandom_range(1, 3);
            queue_setup(sw, sh, fx, fy, ow, oh, nch);
            queue_frames(sw * sh, frames, ($urandom_range(0, 9) == 0) ? 1 : 0);
            pixels_left -= sw * sh * frames;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_jobs.size() == 0);
        @(posedge i_clk);
        while (i_s_tvalid || i_cfg_valid || expected_means.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_means.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
